// ===== src/msra_pkg.sv =====
package msra_pkg;

    localparam int MAX_PAGES = 8;
    localparam int PG_W      = $clog2(MAX_PAGES);
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);

    localparam int DIM_W  = 13;
    localparam int RECT_W = 12;
    localparam int POS_W  = 12;
    localparam int PAD_W  = 4;

    // config register map, word index into the apb space
    localparam int          ADDR_W         = 4;
    localparam logic [1:0]  REG_PAGE_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_PAGE_HEIGHT = 2'd1;
    localparam logic [1:0]  REG_PAD         = 2'd2;

    localparam logic [DIM_W-1:0] PAGE_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0] PAGE_HEIGHT_RST = 13'd1024;
    localparam logic [PAD_W-1:0] PAD_RST         = 4'd1;

    typedef struct packed {
        logic [DIM_W-1:0] cursor_x;
        logic [DIM_W-1:0] cursor_y;
        logic [DIM_W-1:0] row_tallest;
    } page_state_t;

    typedef struct packed {
        logic [RECT_W-1:0] rect_width;
        logic [RECT_W-1:0] rect_height;
        logic [DIM_W-1:0]  page_width;
        logic [DIM_W-1:0]  page_height;
        logic [PAD_W-1:0]  pad;
    } try_req_t;

    typedef struct packed {
        logic             success;
        page_state_t      next_state;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } try_rsp_t;

endpackage

// ===== src/msra_try.sv =====
module msra_try
    import msra_pkg::*;
(
    input  page_state_t cur,
    input  try_req_t    req,
    output try_rsp_t    rsp
);

    logic [DIM_W-1:0] pad2;
    logic [DIM_W-1:0] aw;
    logic [DIM_W-1:0] ah;
    logic             fits_page;
    logic             new_row;
    logic [DIM_W-1:0] cx1;
    logic [DIM_W-1:0] cy1;
    logic [DIM_W-1:0] rt1;
    logic             fits_height;
    logic             success;

    assign pad2 = {{(DIM_W-PAD_W-1){1'b0}}, req.pad, 1'b0};
    assign aw   = {{(DIM_W-RECT_W){1'b0}}, req.rect_width} + pad2;
    assign ah   = {{(DIM_W-RECT_W){1'b0}}, req.rect_height} + pad2;

    assign fits_page = (aw <= req.page_width) && (ah <= req.page_height);

    // row overflow moves to a new shelf
    assign new_row = ({1'b0, cur.cursor_x} + {1'b0, aw}) > {1'b0, req.page_width};
    assign cx1 = new_row ? '0 : cur.cursor_x;
    assign cy1 = new_row ? (cur.cursor_y + cur.row_tallest) : cur.cursor_y;
    assign rt1 = new_row ? '0 : cur.row_tallest;

    assign fits_height = ({1'b0, cy1} + {1'b0, ah}) <= {1'b0, req.page_height};
    assign success     = fits_page && fits_height;

    always_comb
    begin
        rsp.success = success;
        rsp.pos_x   = cx1[POS_W-1:0] + {{(POS_W-PAD_W){1'b0}}, req.pad};
        rsp.pos_y   = cy1[POS_W-1:0] + {{(POS_W-PAD_W){1'b0}}, req.pad};
        if (!fits_page)
        begin
            rsp.next_state = cur;
        end
        else
        begin
            rsp.next_state.cursor_x    = success ? (cx1 + aw) : cx1;
            rsp.next_state.cursor_y    = cy1;
            rsp.next_state.row_tallest = (success && (ah > rt1)) ? ah : rt1;
        end
    end

endmodule

// ===== src/multi_page_shelf_rect_allocator.sv =====
// channel   | signals                                   | direction | beat
// ----------+-------------------------------------------+-----------+---------------------------
// request   | start, busy, rect_width, rect_height      | in        | start && !busy at clk rise
// result    | done, ok, page_index, pos_x, pos_y,       | out       | done high for one cycle
//           | opened_page                               |           |
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out    | psel && penable && pwrite
//           | prdata, pready                            |           |
//
// a request tries t pages, t = 1 to 8, each as a read-modify-write on the page state
// memory, first read launched on the accept edge
// done pulses in the first cycle after the last page, when busy is already low again
// reset clears config to defaults, opens page 0 and marks every page entry empty
// no clearing pass: per-entry valid bits make an empty entry read as zero
// the receiver cannot stall, so nothing holds a result back
module multi_page_shelf_rect_allocator
    import msra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              start,
    output logic              busy,
    input  logic [RECT_W-1:0] rect_width,
    input  logic [RECT_W-1:0] rect_height,

    output logic              done,
    output logic              ok,
    output logic [2:0]        page_index,
    output logic [POS_W-1:0]  pos_x,
    output logic [POS_W-1:0]  pos_y,
    output logic              opened_page,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    // config registers
    logic [DIM_W-1:0] page_width_reg;
    logic [DIM_W-1:0] page_height_reg;
    logic [PAD_W-1:0] pad_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // control
    logic             state_reg,  state_next;
    logic [PG_W-1:0]  page_reg,   page_next;
    logic [CNT_W-1:0] open_reg,   open_next;
    logic [RECT_W-1:0] w_reg;
    logic [RECT_W-1:0] h_reg;

    // page state memory, one entry per page
    page_state_t      page_mem [MAX_PAGES];
    page_state_t      rd_data_reg;
    logic [MAX_PAGES-1:0] vld_reg;
    logic             rd_vld_reg;
    logic [PG_W-1:0]  rd_addr;
    logic             mem_we;

    // result registers
    logic             done_reg,   done_next;
    logic             ok_reg;
    logic [2:0]       page_index_reg;
    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic             opened_reg;
    logic             opened_seen_reg;

    // evaluation
    logic             accept;
    logic             fresh;
    logic             last_try;
    logic             finish;
    page_state_t      cur;
    try_req_t         req;
    try_rsp_t         rsp;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_width_reg  <= PAGE_WIDTH_RST;
            page_height_reg <= PAGE_HEIGHT_RST;
            pad_reg         <= PAD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PAGE_WIDTH:  page_width_reg  <= pwdata[DIM_W-1:0];
                REG_PAGE_HEIGHT: page_height_reg <= pwdata[DIM_W-1:0];
                REG_PAD:         pad_reg         <= pwdata[PAD_W-1:0];
                default:         ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PAGE_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, page_width_reg};
            REG_PAGE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, page_height_reg};
            REG_PAD:         prdata = {{(32-PAD_W){1'b0}}, pad_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- page state memory ----------------
    // page 0 is read on the accept edge, page p+1 while page p is evaluated;
    // write of page p and read of page p+1 never hit the same entry
    assign rd_addr = (state_reg == ST_EVAL) ? (page_reg + 1'b1) : '0;
    assign mem_we  = (state_reg == ST_EVAL);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[page_reg] <= rsp.next_state;
        end
        rd_data_reg <= page_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[page_reg] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // ---------------- evaluation ----------------
    // the page one past the open ones is the freshly opened page: starts empty
    assign fresh = ({1'b0, page_reg} == open_reg);

    always_comb
    begin
        if (fresh || !rd_vld_reg)
        begin
            cur = '0;
        end
        else
        begin
            cur = rd_data_reg;
        end
    end

    always_comb
    begin
        req.rect_width  = w_reg;
        req.rect_height = h_reg;
        req.page_width  = page_width_reg;
        req.page_height = page_height_reg;
        req.pad         = pad_reg;
    end

    msra_try u_try
    (
        .cur (cur),
        .req (req),
        .rsp (rsp)
    );

    // last page: the fresh page, or the final open page when the limit is hit
    assign last_try = fresh
                   || (({1'b0, page_reg} == (open_reg - 1'b1))
                       && (open_reg == CNT_W'(MAX_PAGES)));
    assign finish   = rsp.success || last_try;

    always_comb
    begin
        state_next = state_reg;
        page_next  = page_reg;
        open_next  = open_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                    page_next  = '0;
                end
            end
            ST_EVAL:
            begin
                if (fresh)
                begin
                    open_next = open_reg + 1'b1;
                end
                if (finish)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    page_next = page_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            page_reg        <= '0;
            open_reg        <= CNT_W'(1);
            done_reg        <= 1'b0;
            opened_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            page_reg  <= page_next;
            open_reg  <= open_next;
            done_reg  <= done_next;
            if (accept)
            begin
                opened_seen_reg <= 1'b0;
            end
            else if ((state_reg == ST_EVAL) && fresh)
            begin
                opened_seen_reg <= 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg <= rect_width;
            h_reg <= rect_height;
        end
        if ((state_reg == ST_EVAL) && finish)
        begin
            ok_reg         <= rsp.success;
            page_index_reg <= rsp.success ? 3'(page_reg) : 3'd0;
            pos_x_reg      <= rsp.success ? rsp.pos_x : '0;
            pos_y_reg      <= rsp.success ? rsp.pos_y : '0;
            opened_reg     <= fresh;
        end
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign page_index  = page_index_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign opened_page = opened_reg;

`ifndef SYNTHESIS
    // result beat only lands once the walk is over
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result beat while walking pages");

    // open page count stays between one and the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg >= CNT_W'(1)) && (open_reg <= CNT_W'(MAX_PAGES)))
        else $error("open page count out of range");

    // a request that opens a page grows the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && opened_reg) |-> (open_reg == $past(open_reg) + 1'b1))
        else $error("opened page without count increment");

    // the walk never goes beyond the fresh page
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> ({1'b0, page_reg} <= open_reg))
        else $error("page walk past the open pages");

    // a placed rectangle lies on an open page
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ok_reg) |-> ({1'b0, page_index_reg} < open_reg))
        else $error("placement on a page that is not open");

    // only the fresh page can be reported as opened
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (opened_reg == opened_seen_reg))
        else $error("opened flag disagrees with the walk");
`endif

endmodule
